FILE: src/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// shared types and constants of the bounding box block
// ----------------------------------------------------------------------------
package aabb_pkg;

    localparam int POS_W      = 16;   // signed q8.8 input coordinate
    localparam int PROD_W     = 32;   // one coefficient times one coordinate
    localparam int COORD_W    = 34;   // signed q.16 transformed coordinate
    localparam int AXES       = 3;
    localparam int COLS       = 4;
    localparam int ROW_W      = COLS * POS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int FRAC_SHIFT = 8;    // q8.8 to q.16 without transform
    localparam int QUEUE_DEPTH = 4;

    localparam logic [COORD_W-1:0] COORD_POS_LIMIT = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_NEG_LIMIT = {1'b1, {(COORD_W-1){1'b0}}};

    // identity rows at reset: 1.0 in the matching column
    localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_0100;
    localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_0000_0100_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'h0000_0100_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRANSFORM_ENABLE,
        REG_ROW_X,
        REG_ROW_Y,
        REG_ROW_Z
    } cfg_reg_t;

    // one classified vertex travelling from front to back
    typedef struct packed {
        logic                           vertex_valid;
        logic                           last_vertex;
        logic [AXES-1:0][COORD_W-1:0]   coord;
    } point_t;

endpackage

FILE: src/aabb_vertex_if.sv
// ----------------------------------------------------------------------------
// aabb_vertex_if
// vertex input channel
// ----------------------------------------------------------------------------
interface aabb_vertex_if;

    logic                                 valid;
    logic                                 ready;
    logic                                 vertex_valid;
    logic signed [aabb_pkg::POS_W-1:0]    pos_x;
    logic signed [aabb_pkg::POS_W-1:0]    pos_y;
    logic signed [aabb_pkg::POS_W-1:0]    pos_z;
    logic signed [aabb_pkg::POS_W-1:0]    pos_w;
    logic                                 last_vertex;

    modport source (
        output valid, vertex_valid, pos_x, pos_y, pos_z, pos_w, last_vertex,
        input  ready
    );

    modport sink (
        input  valid, vertex_valid, pos_x, pos_y, pos_z, pos_w, last_vertex,
        output ready
    );

endinterface

FILE: src/aabb_box_if.sv
// ----------------------------------------------------------------------------
// aabb_box_if
// bounding box result channel
// ----------------------------------------------------------------------------
interface aabb_box_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [aabb_pkg::COORD_W-1:0]  min_x;
    logic signed [aabb_pkg::COORD_W-1:0]  min_y;
    logic signed [aabb_pkg::COORD_W-1:0]  min_z;
    logic signed [aabb_pkg::COORD_W-1:0]  max_x;
    logic signed [aabb_pkg::COORD_W-1:0]  max_y;
    logic signed [aabb_pkg::COORD_W-1:0]  max_z;

    modport source (
        output valid, min_x, min_y, min_z, max_x, max_y, max_z,
        input  ready
    );

    modport sink (
        input  valid, min_x, min_y, min_z, max_x, max_y, max_z,
        output ready
    );

endinterface

FILE: src/aabb_cfg_if.sv
// ----------------------------------------------------------------------------
// aabb_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
interface aabb_cfg_if;

    logic                                valid;
    logic                                ready;
    logic [aabb_pkg::CFG_IDX_W-1:0]      index;
    logic [aabb_pkg::CFG_DATA_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );

endinterface

FILE: src/aabb_front.sv
// ----------------------------------------------------------------------------
// aabb_front
// config registers, vertex intake and two-stage transform pipeline
// ----------------------------------------------------------------------------
module aabb_front (
    input  logic                 clk,
    input  logic                 rst_n,
    aabb_cfg_if.sink             cfg,
    aabb_vertex_if.sink          vertex,
    output logic                 push_valid,
    input  logic                 push_ready,
    output aabb_pkg::point_t     push_data
);

    localparam int PROD_W  = aabb_pkg::PROD_W;
    localparam int COORD_W = aabb_pkg::COORD_W;
    localparam int POS_W   = aabb_pkg::POS_W;

    logic                                        transform_enable_reg;
    logic [aabb_pkg::AXES-1:0][aabb_pkg::ROW_W-1:0] row_reg;

    // stage 1: products
    logic        s1_valid_reg;
    logic        s1_vv_reg;
    logic        s1_last_reg;
    logic signed [PROD_W-1:0] s1_prod_reg [aabb_pkg::AXES][aabb_pkg::COLS];
    logic signed [PROD_W-1:0] s1_prod_next [aabb_pkg::AXES][aabb_pkg::COLS];

    // stage 2: dot products
    logic             s2_valid_reg;
    aabb_pkg::point_t s2_point_reg;
    aabb_pkg::point_t s2_point_next;

    logic signed [POS_W-1:0] vec [aabb_pkg::COLS];
    logic s1_adv;
    logic s2_adv;
    logic take;

    assign cfg.ready = 1'b1;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transform_enable_reg <= 1'b0;
            row_reg[0]           <= aabb_pkg::ROW_X_RESET;
            row_reg[1]           <= aabb_pkg::ROW_Y_RESET;
            row_reg[2]           <= aabb_pkg::ROW_Z_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (aabb_pkg::cfg_reg_t'(cfg.index))
                aabb_pkg::REG_TRANSFORM_ENABLE: transform_enable_reg <= cfg.data[0];
                aabb_pkg::REG_ROW_X:            row_reg[0] <= cfg.data;
                aabb_pkg::REG_ROW_Y:            row_reg[1] <= cfg.data;
                aabb_pkg::REG_ROW_Z:            row_reg[2] <= cfg.data;
            endcase
        end
    end

    assign s2_adv       = !s2_valid_reg || push_ready;
    assign s1_adv       = !s1_valid_reg || s2_adv;
    assign vertex.ready = s1_adv;
    // bare items change nothing, so they are dropped here
    assign take = vertex.valid && s1_adv && (vertex.vertex_valid || vertex.last_vertex);

    assign vec[0] = vertex.pos_x;
    assign vec[1] = vertex.pos_y;
    assign vec[2] = vertex.pos_z;
    assign vec[3] = vertex.pos_w;

    always_comb
    begin
        for (int a = 0; a < aabb_pkg::AXES; a++)
        begin
            for (int k = 0; k < aabb_pkg::COLS; k++)
            begin
                if (transform_enable_reg)
                    s1_prod_next[a][k] = $signed(row_reg[a][k*POS_W +: POS_W]) * vec[k];
                else if (k == a)
                    s1_prod_next[a][k] = {{(PROD_W-POS_W-aabb_pkg::FRAC_SHIFT){vec[k][POS_W-1]}},
                                          vec[k], {aabb_pkg::FRAC_SHIFT{1'b0}}};
                else
                    s1_prod_next[a][k] = '0;
            end
        end
    end

    always_comb
    begin
        s2_point_next.vertex_valid = s1_vv_reg;
        s2_point_next.last_vertex  = s1_last_reg;
        for (int a = 0; a < aabb_pkg::AXES; a++)
        begin
            s2_point_next.coord[a] =
                {{(COORD_W-PROD_W){s1_prod_reg[a][0][PROD_W-1]}}, s1_prod_reg[a][0]} +
                {{(COORD_W-PROD_W){s1_prod_reg[a][1][PROD_W-1]}}, s1_prod_reg[a][1]} +
                {{(COORD_W-PROD_W){s1_prod_reg[a][2][PROD_W-1]}}, s1_prod_reg[a][2]} +
                {{(COORD_W-PROD_W){s1_prod_reg[a][3][PROD_W-1]}}, s1_prod_reg[a][3]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= take;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_vv_reg   <= vertex.vertex_valid;
            s1_last_reg <= vertex.last_vertex;
            s1_prod_reg <= s1_prod_next;
        end
        if (s2_adv && s1_valid_reg)
            s2_point_reg <= s2_point_next;
    end

    assign push_valid = s2_valid_reg;
    assign push_data  = s2_point_reg;

endmodule

FILE: src/aabb_queue.sv
// ----------------------------------------------------------------------------
// aabb_queue
// short queue of classified vertices between front and back
// ----------------------------------------------------------------------------
module aabb_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  aabb_pkg::point_t     push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output aabb_pkg::point_t     pop_data
);

    localparam int DEPTH = aabb_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aabb_pkg::point_t  mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic push;
    logic pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: src/aabb_back.sv
// ----------------------------------------------------------------------------
// aabb_back
// running min/max per axis and box output register
// ----------------------------------------------------------------------------
module aabb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  aabb_pkg::point_t     pop_data,
    aabb_box_if.source           box
);

    localparam int COORD_W = aabb_pkg::COORD_W;
    localparam int AXES    = aabb_pkg::AXES;

    logic signed [COORD_W-1:0] min_reg  [AXES];
    logic signed [COORD_W-1:0] max_reg  [AXES];
    logic signed [COORD_W-1:0] min_next [AXES];
    logic signed [COORD_W-1:0] max_next [AXES];
    logic signed [COORD_W-1:0] lo_next  [AXES];
    logic signed [COORD_W-1:0] hi_next  [AXES];
    logic signed [COORD_W-1:0] lo_reg   [AXES];
    logic signed [COORD_W-1:0] hi_reg   [AXES];
    logic any_seen_reg;
    logic any_seen_next;
    logic out_valid_reg;
    logic out_free;
    logic pop;
    logic emit;

    assign out_free  = !out_valid_reg || box.ready;
    assign pop_ready = !pop_data.last_vertex || out_free;
    assign pop       = pop_valid && pop_ready;
    assign emit      = pop && pop_data.last_vertex;

    assign any_seen_next = any_seen_reg || pop_data.vertex_valid;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            min_next[a] = min_reg[a];
            max_next[a] = max_reg[a];
            if (pop_data.vertex_valid && ($signed(pop_data.coord[a]) < min_reg[a]))
                min_next[a] = $signed(pop_data.coord[a]);
            if (pop_data.vertex_valid && ($signed(pop_data.coord[a]) > max_reg[a]))
                max_next[a] = $signed(pop_data.coord[a]);
            // empty set gives an all-zero box
            lo_next[a] = any_seen_next ? min_next[a] : '0;
            hi_next[a] = any_seen_next ? max_next[a] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                min_reg[a] <= $signed(aabb_pkg::COORD_POS_LIMIT);
                max_reg[a] <= $signed(aabb_pkg::COORD_NEG_LIMIT);
            end
            any_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    min_reg[a] <= $signed(aabb_pkg::COORD_POS_LIMIT);
                    max_reg[a] <= $signed(aabb_pkg::COORD_NEG_LIMIT);
                end
                any_seen_reg <= 1'b0;
            end
            else if (pop)
            begin
                min_reg      <= min_next;
                max_reg      <= max_next;
                any_seen_reg <= any_seen_next;
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (box.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign box.valid = out_valid_reg;
    assign box.min_x = lo_reg[0];
    assign box.min_y = lo_reg[1];
    assign box.min_z = lo_reg[2];
    assign box.max_x = hi_reg[0];
    assign box.max_y = hi_reg[1];
    assign box.max_z = hi_reg[2];

    // a box always restarts the set
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> !any_seen_reg)
        else $error("set not cleared after box");

    // with no vertex seen the running x min and z max sit at their start values
    a_empty_limits: assert property (@(posedge clk) disable iff (!rst_n)
        !any_seen_reg |-> (min_reg[0] == $signed(aabb_pkg::COORD_POS_LIMIT)
                           && max_reg[2] == $signed(aabb_pkg::COORD_NEG_LIMIT)))
        else $error("running limits moved without a vertex");

    // once a vertex is in, min never exceeds max
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        any_seen_reg |-> (min_reg[0] <= max_reg[0] && min_reg[1] <= max_reg[1]
                          && min_reg[2] <= max_reg[2]))
        else $error("running min above running max");

endmodule

FILE: src/aabb_from_vertex_stream_top.sv
// ----------------------------------------------------------------------------
// aabb_from_vertex_stream_top
// axis-aligned bounding box of a vertex stream with optional affine transform
// ----------------------------------------------------------------------------
// Takes one vertex transaction per clock unless stalled (signed q8.8 x, y,
// z, w) and returns one box transaction (signed q.16 min/max per axis) for
// every item marked last. With transform_enable set, each axis is the exact
// dot product of the vertex with a configured row of four q8.8 coefficients;
// otherwise xyz are shifted left by 8. A set with no valid vertex yields an
// all-zero box. The sustained rate is one vertex per cycle while the queue
// has room: the transform is a two-stage pipeline (twelve 16x16 products,
// then three four-way sums) and the min/max update in the back end takes
// one vertex per cycle. A last vertex passes the first transform stage, the
// second stage, the queue and the output register in that order before its
// box is valid. A box held on the output stalls the next last item; vertices
// behind it fill the queue meanwhile. Bare items with neither vertex nor last
// flag are dropped at intake. Config writes are always accepted and should
// be issued while no vertex is in flight.
// ----------------------------------------------------------------------------
module aabb_from_vertex_stream_top (
    input  logic         clk,
    input  logic         rst_n,
    aabb_cfg_if.sink     cfg,
    aabb_vertex_if.sink  vertex,
    aabb_box_if.source   box
);

    // front to queue
    logic             push_valid;
    logic             push_ready;
    aabb_pkg::point_t push_data;

    // queue to back
    logic             pop_valid;
    logic             pop_ready;
    aabb_pkg::point_t pop_data;

    // intake, config registers and transform pipeline
    aabb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .vertex     (vertex),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decouples the transform pipeline from a stalled box output
    aabb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // running min/max and box output register
    aabb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .box       (box)
    );

endmodule
